// ----- rtl/tsw_pkg.sv -----
package tsw_pkg;

  localparam int COORD_W     = 24;
  localparam int CHAN_W      = 16;
  localparam int TEX_IDX_W   = 8;
  localparam int SIZE_W      = 9;
  localparam int REG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 8;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] BORDER_CLAMP  = 2'd0;
  localparam logic [1:0] BORDER_MIRROR = 2'd1;
  localparam logic [1:0] BORDER_REPEAT = 2'd2;

  localparam logic FILTER_NEAREST  = 1'b0;
  localparam logic FILTER_BILINEAR = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_BORDER = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FILTER = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

endpackage

// ----- rtl/tsw_front.sv -----
module tsw_front #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int CHANNEL_BITS = 16,
  parameter int FRAC_BITS    = 16,
  parameter int ENTRY_W      = 1 + 2 * $clog2(MAX_WIDTH) + 2 * $clog2(MAX_HEIGHT)
                               + 4 * (2 * FRAC_BITS + 1) + 3 * CHANNEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_en,
  input  logic [tsw_pkg::REG_IDX_W-1:0]     reg_index,
  input  logic [tsw_pkg::SIZE_W-1:0]        write_data,
  input  logic                              accept,
  input  logic                              opcode,
  input  logic [tsw_pkg::TEX_IDX_W-1:0]     texel_col,
  input  logic [tsw_pkg::TEX_IDX_W-1:0]     texel_row,
  input  logic [tsw_pkg::CHAN_W-1:0]        texel_red,
  input  logic [tsw_pkg::CHAN_W-1:0]        texel_green,
  input  logic [tsw_pkg::CHAN_W-1:0]        texel_blue,
  input  logic signed [tsw_pkg::COORD_W-1:0] coord_u,
  input  logic signed [tsw_pkg::COORD_W-1:0] coord_v,
  output logic                              push,
  output logic [ENTRY_W-1:0]                entry,
  output logic [2:0]                        inflight
);
  import tsw_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int IW = (XW > YW) ? XW : YW;
  localparam int SW = FRAC_BITS + 1 + IW;
  localparam int WW = 2 * FRAC_BITS + 1;
  localparam int TW = 3 * CHANNEL_BITS;
  localparam int PW = 2 * IW + FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SW:0] HALF = {{(SW - FRAC_BITS + 1){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  typedef struct packed {
    logic          op;
    logic [XW-1:0] fx;
    logic [XW-1:0] nx;
    logic [YW-1:0] fy;
    logic [YW-1:0] ny;
    logic [WW-1:0] w00;
    logic [WW-1:0] w01;
    logic [WW-1:0] w10;
    logic [WW-1:0] w11;
    logic [TW-1:0] texel;
  } entry_t;

  // fold a coordinate into [0, one]
  function automatic logic [FRAC_BITS:0] fold(input logic signed [COORD_W-1:0] c,
                                               input logic [1:0] mode);
    logic [COORD_W-1:0]   a;
    logic [FRAC_BITS:0]   f;
    logic [FRAC_BITS:0]   frac;
    begin
      a    = c[COORD_W-1] ? COORD_W'(-c) : $unsigned(c);
      frac = {1'b0, a[FRAC_BITS-1:0]};
      case (mode)
        BORDER_MIRROR: f = a[FRAC_BITS] ? ONE - frac : frac;
        BORDER_REPEAT: f = c[COORD_W-1] ? ONE - frac : frac;
        default: begin
          if (c[COORD_W-1]) f = '0;
          else if ($unsigned(c) > {{(COORD_W - FRAC_BITS - 1){1'b0}}, ONE}) f = ONE;
          else f = c[FRAC_BITS:0];
        end
      endcase
      return f;
    end
  endfunction

  // pick low index, high index and fraction along one axis
  function automatic logic [PW-1:0] axis_pick(input logic [SW-1:0] s,
                                              input logic [IW-1:0] m1,
                                              input logic bil);
    logic [IW:0]        lo;
    logic [IW:0]        hi;
    logic [FRAC_BITS:0] d;
    logic [SW:0]        r;
    begin
      r = {1'b0, s} + HALF;
      if (bil) begin
        lo = {1'b0, s[FRAC_BITS +: IW]};
        d  = {1'b0, s[FRAC_BITS-1:0]};
        if (s[FRAC_BITS-1:0] == '0 && s != '0) begin
          lo = lo - 1'b1;
          d  = ONE;
        end
        hi = lo + 1'b1;
        if (hi > {1'b0, m1}) begin
          hi = {1'b0, m1};
          d  = '0;
        end
      end else begin
        lo = r[FRAC_BITS +: IW + 1];
        if (lo > {1'b0, m1}) lo = {1'b0, m1};
        hi = lo;
        d  = '0;
      end
      return {lo[IW-1:0], hi[IW-1:0], d};
    end
  endfunction

  logic [1:0]        border_mode;
  logic              filter_mode;
  logic [SIZE_W-1:0] width_in_use;
  logic [SIZE_W-1:0] height_in_use;
  logic [IW-1:0]     wm1;
  logic [IW-1:0]     hm1;

  always_ff @(posedge clk) begin
    if (rst) begin
      border_mode   <= BORDER_CLAMP;
      filter_mode   <= FILTER_NEAREST;
      width_in_use  <= SIZE_RESET;
      height_in_use <= SIZE_RESET;
    end else if (write_en) begin
      case (reg_index)
        REG_BORDER: border_mode   <= write_data[1:0];
        REG_FILTER: filter_mode   <= write_data[0];
        REG_WIDTH:  width_in_use  <= write_data;
        REG_HEIGHT: height_in_use <= write_data;
        default: ;
      endcase
    end
  end

  // size minus one, with zero read as one and big values saturated
  always_comb begin
    if (width_in_use == '0) wm1 = '0;
    else if (int'(width_in_use) > MAX_WIDTH) wm1 = IW'(MAX_WIDTH - 1);
    else wm1 = IW'(width_in_use - 1'b1);
    if (height_in_use == '0) hm1 = '0;
    else if (int'(height_in_use) > MAX_HEIGHT) hm1 = IW'(MAX_HEIGHT - 1);
    else hm1 = IW'(height_in_use - 1'b1);
  end

  logic               in_range;
  logic               a_v, b_v, c_v, d_v;
  logic               a_op, b_op, c_op;
  logic [XW-1:0]      a_col, b_col;
  logic [YW-1:0]      a_row, b_row;
  logic [TW-1:0]      a_texel, b_texel, c_texel;
  logic [FRAC_BITS:0] a_fu, a_fv;
  logic [SW-1:0]      b_sx, b_sy;
  logic [XW-1:0]      c_fx, c_nx;
  logic [YW-1:0]      c_fy, c_ny;
  logic [FRAC_BITS:0] c_dx, c_dy;
  logic [PW-1:0]      xs, ys;
  logic [FRAC_BITS:0] odx, ody;
  entry_t             d_q;

  assign in_range = (opcode == OP_SAMPLE) ||
                    ((int'(texel_col) < MAX_WIDTH) && (int'(texel_row) < MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else begin
      a_v <= accept && in_range;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
    end
  end

  // fold
  always_ff @(posedge clk) begin
    a_op    <= opcode;
    a_col   <= XW'(texel_col);
    a_row   <= YW'(texel_row);
    a_texel <= {texel_red[CHANNEL_BITS-1:0], texel_green[CHANNEL_BITS-1:0],
                texel_blue[CHANNEL_BITS-1:0]};
    a_fu    <= fold(coord_u, border_mode);
    a_fv    <= fold(coord_v, border_mode);
  end

  // scale by size minus one
  always_ff @(posedge clk) begin
    b_op    <= a_op;
    b_col   <= a_col;
    b_row   <= a_row;
    b_texel <= a_texel;
    b_sx    <= SW'(a_fu) * SW'(wm1);
    b_sy    <= SW'(a_fv) * SW'(hm1);
  end

  always_comb begin
    xs = axis_pick(b_sx, wm1, filter_mode == FILTER_BILINEAR);
    ys = axis_pick(b_sy, hm1, filter_mode == FILTER_BILINEAR);
  end

  // neighbour indices and fractions; writes carry their address as a 1x1 footprint
  always_ff @(posedge clk) begin
    c_op    <= b_op;
    c_texel <= b_texel;
    c_dx    <= xs[FRAC_BITS:0];
    c_dy    <= ys[FRAC_BITS:0];
    if (b_op == OP_WRITE) begin
      c_fx <= b_col;
      c_nx <= b_col;
      c_fy <= b_row;
      c_ny <= b_row;
    end else begin
      c_fx <= XW'(xs[PW-1 -: IW]);
      c_nx <= XW'(xs[FRAC_BITS + 1 +: IW]);
      c_fy <= YW'(ys[PW-1 -: IW]);
      c_ny <= YW'(ys[FRAC_BITS + 1 +: IW]);
    end
  end

  assign odx = ONE - c_dx;
  assign ody = ONE - c_dy;

  // blend weights
  always_ff @(posedge clk) begin
    d_q.op    <= c_op;
    d_q.fx    <= c_fx;
    d_q.nx    <= c_nx;
    d_q.fy    <= c_fy;
    d_q.ny    <= c_ny;
    d_q.texel <= c_texel;
    d_q.w00   <= WW'(odx) * WW'(ody);
    d_q.w01   <= WW'(odx) * WW'(c_dy);
    d_q.w10   <= WW'(c_dx) * WW'(ody);
    d_q.w11   <= WW'(c_dx) * WW'(c_dy);
  end

  assign push     = d_v;
  assign entry    = d_q;
  assign inflight = 3'($countones({a_v, b_v, c_v, d_v}));

endmodule

// ----- rtl/tsw_queue.sv -----
module tsw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] fill
);
  import tsw_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign dout  = slots[rd_ptr];
  assign empty = (fill == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (int'(fill) < DEPTH) || pop)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != '0)
    else $error("queue underflow");

  a_fill_tracks_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill != '0 && int'(fill) < DEPTH) |-> wr_ptr != rd_ptr)
    else $error("queue pointers disagree with fill");

endmodule

// ----- rtl/tsw_back.sv -----
module tsw_back #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int CHANNEL_BITS = 16,
  parameter int FRAC_BITS    = 16,
  parameter int ENTRY_W      = 1 + 2 * $clog2(MAX_WIDTH) + 2 * $clog2(MAX_HEIGHT)
                               + 4 * (2 * FRAC_BITS + 1) + 3 * CHANNEL_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid_in,
  input  logic [ENTRY_W-1:0]         entry,
  output logic                       done,
  output logic [tsw_pkg::CHAN_W-1:0] sample_red,
  output logic [tsw_pkg::CHAN_W-1:0] sample_green,
  output logic [tsw_pkg::CHAN_W-1:0] sample_blue
);
  import tsw_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int XHW = (XW > 1) ? XW - 1 : 1;
  localparam int YHW = (YW > 1) ? YW - 1 : 1;
  localparam int AW  = XHW + YHW;
  localparam int BANK_DEPTH = 1 << AW;
  localparam int WW  = 2 * FRAC_BITS + 1;
  localparam int TW  = 3 * CHANNEL_BITS;
  localparam int MW  = CHANNEL_BITS + WW;
  localparam int SUMW = MW + 2;
  localparam logic [SUMW-1:0] ROUND = SUMW'(1) << (2 * FRAC_BITS - 1);

  typedef struct packed {
    logic          op;
    logic [XW-1:0] fx;
    logic [XW-1:0] nx;
    logic [YW-1:0] fy;
    logic [YW-1:0] ny;
    logic [WW-1:0] w00;
    logic [WW-1:0] w01;
    logic [WW-1:0] w10;
    logic [WW-1:0] w11;
    logic [TW-1:0] texel;
  } entry_t;

  entry_t        e;
  logic [TW-1:0] rdata [4];

  assign e = entry;

  // four banks by column and row parity, so a 2x2 footprint hits each once
  for (genvar bk = 0; bk < 4; bk++) begin : g_bank
    localparam logic CP = 1'(bk % 2);
    localparam logic RP = 1'(bk / 2);
    logic [TW-1:0] mem [BANK_DEPTH];
    logic [XW-1:0] col;
    logic [YW-1:0] row;
    logic [AW-1:0] addr;
    logic          we;

    assign col  = (e.fx[0] == CP) ? e.fx : e.nx;
    assign row  = (e.fy[0] == RP) ? e.fy : e.ny;
    assign addr = {YHW'(row >> 1), XHW'(col >> 1)};
    assign we   = valid_in && (e.op == OP_WRITE) && (e.fx[0] == CP) && (e.fy[0] == RP);

    always_ff @(posedge clk) begin
      if (we) mem[addr] <= e.texel;
      rdata[bk] <= mem[addr];
    end
  end

  logic          r_v;
  logic          r_fx0, r_nx0, r_fy0, r_ny0;
  logic [WW-1:0] r_w [4];

  always_ff @(posedge clk) begin
    if (rst) r_v <= 1'b0;
    else r_v <= valid_in && (e.op == OP_SAMPLE);
  end

  always_ff @(posedge clk) begin
    r_fx0  <= e.fx[0];
    r_nx0  <= e.nx[0];
    r_fy0  <= e.fy[0];
    r_ny0  <= e.ny[0];
    r_w[0] <= e.w00;
    r_w[1] <= e.w01;
    r_w[2] <= e.w10;
    r_w[3] <= e.w11;
  end

  logic [TW-1:0] corner [4];

  always_comb begin
    corner[0] = rdata[{r_fy0, r_fx0}];
    corner[1] = rdata[{r_ny0, r_fx0}];
    corner[2] = rdata[{r_fy0, r_nx0}];
    corner[3] = rdata[{r_ny0, r_nx0}];
  end

  logic          p_v;
  logic [MW-1:0] prod [3][4];

  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else p_v <= r_v;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 4; j++) begin
        prod[k][j] <= MW'(corner[j][(2 - k) * CHANNEL_BITS +: CHANNEL_BITS]) * MW'(r_w[j]);
      end
    end
  end

  logic [SUMW-1:0] acc [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = SUMW'(prod[k][0]) + SUMW'(prod[k][1]) + SUMW'(prod[k][2])
             + SUMW'(prod[k][3]) + ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= p_v;
  end

  always_ff @(posedge clk) begin
    sample_red   <= CHAN_W'(acc[0] >> (2 * FRAC_BITS));
    sample_green <= CHAN_W'(acc[1] >> (2 * FRAC_BITS));
    sample_blue  <= CHAN_W'(acc[2] >> (2 * FRAC_BITS));
  end

endmodule

// ----- rtl/texture_sampler_wrap_bilinear_top.sv -----
// Texture sampler. Requests enter on start while busy is low, one per clock, and
// are either texel writes (opcode 0) or samples (opcode 1). A sample folds u and v
// into [0,1] by clamp, mirror or repeat, scales by size minus one and returns one
// texel (nearest) or a rounded four-texel blend (bilinear). Each sample yields one
// result on sample_red/green/blue, strobed by done for exactly one cycle: its request
// passes the fold, scale, footprint and weight registers, the queue, the bank read,
// the weighted products and the rounded sum, registered with done; writes yield
// nothing. The receiver cannot stall, so results must be taken when done is high.
// Throughput is one request per clock, set by the four parity banks of the texel
// memory that give all four neighbours in a single read cycle. Texel memory is not
// cleared: sample only texels that have been written. Configuration registers must
// be written only when no request is in flight; the block does not enforce this.
module texture_sampler_wrap_bilinear_top #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int CHANNEL_BITS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_en,
  input  logic [tsw_pkg::REG_IDX_W-1:0]      reg_index,
  input  logic [tsw_pkg::SIZE_W-1:0]         write_data,
  input  logic                               start,
  output logic                               busy,
  input  logic                               opcode,
  input  logic [tsw_pkg::TEX_IDX_W-1:0]      texel_col,
  input  logic [tsw_pkg::TEX_IDX_W-1:0]      texel_row,
  input  logic [tsw_pkg::CHAN_W-1:0]         texel_red,
  input  logic [tsw_pkg::CHAN_W-1:0]         texel_green,
  input  logic [tsw_pkg::CHAN_W-1:0]         texel_blue,
  input  logic signed [tsw_pkg::COORD_W-1:0] coord_u,
  input  logic signed [tsw_pkg::COORD_W-1:0] coord_v,
  output logic                               done,
  output logic [tsw_pkg::CHAN_W-1:0]         sample_red,
  output logic [tsw_pkg::CHAN_W-1:0]         sample_green,
  output logic [tsw_pkg::CHAN_W-1:0]         sample_blue
);
  import tsw_pkg::*;

  // one queue entry: op, footprint indices, four weights, write data
  localparam int ENTRY_W = 1 + 2 * $clog2(MAX_WIDTH) + 2 * $clog2(MAX_HEIGHT)
                         + 4 * (2 * FRAC_BITS + 1) + 3 * CHANNEL_BITS;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);

  logic               accept;
  logic               push;
  logic               pop;
  logic               q_empty;
  logic [ENTRY_W-1:0] f_entry;
  logic [ENTRY_W-1:0] q_entry;
  logic [2:0]         inflight;
  logic [FILL_W-1:0]  q_fill;

  // a request is taken whenever start is high and we are not holding off
  assign accept = start && !busy;

  // hold off only when the front stages plus queued work could overrun the queue;
  // the back end drains one entry per clock, so this stays low in normal streaming
  assign busy = (int'(inflight) + int'(q_fill)) >= QUEUE_DEPTH;

  // front: config registers, folding, scaling, footprint and weights
  tsw_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .CHANNEL_BITS (CHANNEL_BITS),
    .FRAC_BITS    (FRAC_BITS),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .reg_index   (reg_index),
    .write_data  (write_data),
    .accept      (accept),
    .opcode      (opcode),
    .texel_col   (texel_col),
    .texel_row   (texel_row),
    .texel_red   (texel_red),
    .texel_green (texel_green),
    .texel_blue  (texel_blue),
    .coord_u     (coord_u),
    .coord_v     (coord_v),
    .push        (push),
    .entry       (f_entry),
    .inflight    (inflight)
  );

  // short queue between the two halves
  tsw_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_entry),
    .pop   (pop),
    .dout  (q_entry),
    .empty (q_empty),
    .fill  (q_fill)
  );

  // back end never stalls, so it takes the head entry every cycle there is one
  assign pop = !q_empty;

  // back: banked texel memory, weighted blend, rounding
  tsw_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .CHANNEL_BITS (CHANNEL_BITS),
    .FRAC_BITS    (FRAC_BITS),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .valid_in     (pop),
    .entry        (q_entry),
    .done         (done),
    .sample_red   (sample_red),
    .sample_green (sample_green),
    .sample_blue  (sample_blue)
  );

endmodule
